>>> hw/rtl/svwm_pkg.sv
// ----------------------------------------------------------------------------
// svwm_pkg
// Shared types and constants for the supply voltage window monitor.
// ----------------------------------------------------------------------------
package svwm_pkg;

  localparam int VoltW  = 12;
  localparam int DelayW = 16;
  localparam int StateW = 2;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [StateW-1:0] MODE_INITIAL = 2'd0;
  localparam logic [StateW-1:0] MODE_NORMAL  = 2'd1;
  localparam logic [StateW-1:0] MODE_OVER    = 2'd2;
  localparam logic [StateW-1:0] MODE_UNDER   = 2'd3;

  localparam logic [2:0] REG_UNDER_LIMIT         = 3'd0;
  localparam logic [2:0] REG_OVER_LIMIT          = 3'd1;
  localparam logic [2:0] REG_OVER_RECOVER_LIMIT  = 3'd2;
  localparam logic [2:0] REG_UNDER_RECOVER_LIMIT = 3'd3;
  localparam logic [2:0] REG_FIRST_DELAY         = 3'd4;
  localparam logic [2:0] REG_RECOVER_DELAY       = 3'd5;

  localparam logic [VoltW-1:0]  RST_UNDER_LIMIT         = 12'd90;
  localparam logic [VoltW-1:0]  RST_OVER_LIMIT          = 12'd160;
  localparam logic [VoltW-1:0]  RST_OVER_RECOVER_LIMIT  = 12'd155;
  localparam logic [VoltW-1:0]  RST_UNDER_RECOVER_LIMIT = 12'd95;
  localparam logic [DelayW-1:0] RST_FIRST_DELAY         = 16'd10;
  localparam logic [DelayW-1:0] RST_RECOVER_DELAY       = 16'd10;

  typedef struct packed {
    logic [VoltW-1:0]  under_limit;
    logic [VoltW-1:0]  over_limit;
    logic [VoltW-1:0]  over_recover_limit;
    logic [VoltW-1:0]  under_recover_limit;
    logic [DelayW-1:0] first_delay;
    logic [DelayW-1:0] recover_delay;
  } cfg_t;

endpackage

>>> hw/rtl/svwm_regs.sv
// ----------------------------------------------------------------------------
// svwm_regs
// APB register file holding the thresholds and delays.
// ----------------------------------------------------------------------------
module svwm_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [svwm_pkg::AddrW-1:0] paddr,
  input  logic [svwm_pkg::DataW-1:0] pwdata,
  output logic [svwm_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output svwm_pkg::cfg_t             cfg
);
  import svwm_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.under_limit         <= RST_UNDER_LIMIT;
      cfg.over_limit          <= RST_OVER_LIMIT;
      cfg.over_recover_limit  <= RST_OVER_RECOVER_LIMIT;
      cfg.under_recover_limit <= RST_UNDER_RECOVER_LIMIT;
      cfg.first_delay         <= RST_FIRST_DELAY;
      cfg.recover_delay       <= RST_RECOVER_DELAY;
    end else if (wr_en) begin
      unique case (idx)
        REG_UNDER_LIMIT:         cfg.under_limit         <= pwdata[VoltW-1:0];
        REG_OVER_LIMIT:          cfg.over_limit          <= pwdata[VoltW-1:0];
        REG_OVER_RECOVER_LIMIT:  cfg.over_recover_limit  <= pwdata[VoltW-1:0];
        REG_UNDER_RECOVER_LIMIT: cfg.under_recover_limit <= pwdata[VoltW-1:0];
        REG_FIRST_DELAY:         cfg.first_delay         <= pwdata[DelayW-1:0];
        REG_RECOVER_DELAY:       cfg.recover_delay       <= pwdata[DelayW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_UNDER_LIMIT:         prdata = {{(DataW-VoltW){1'b0}}, cfg.under_limit};
      REG_OVER_LIMIT:          prdata = {{(DataW-VoltW){1'b0}}, cfg.over_limit};
      REG_OVER_RECOVER_LIMIT:  prdata = {{(DataW-VoltW){1'b0}}, cfg.over_recover_limit};
      REG_UNDER_RECOVER_LIMIT: prdata = {{(DataW-VoltW){1'b0}}, cfg.under_recover_limit};
      REG_FIRST_DELAY:         prdata = {{(DataW-DelayW){1'b0}}, cfg.first_delay};
      REG_RECOVER_DELAY:       prdata = {{(DataW-DelayW){1'b0}}, cfg.recover_delay};
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/svwm_fsm.sv
// ----------------------------------------------------------------------------
// svwm_fsm
// Supply classification state and countdown, one update per item.
// ----------------------------------------------------------------------------
module svwm_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [svwm_pkg::VoltW-1:0]  volt,
  input  svwm_pkg::cfg_t              cfg,
  output logic [svwm_pkg::StateW-1:0] mode,
  output logic [svwm_pkg::StateW-1:0] mode_next,
  output logic [svwm_pkg::DelayW-1:0] countdown
);
  import svwm_pkg::*;

  logic [DelayW-1:0] countdown_next;
  logic [DelayW-1:0] cd_dec;
  logic              expired;

  // countdown at 0 or 1 finishes the delay
  assign expired = (countdown <= {{(DelayW-1){1'b0}}, 1'b1});
  assign cd_dec  = expired ? '0 : countdown - {{(DelayW-1){1'b0}}, 1'b1};

  always_comb begin
    mode_next      = mode;
    countdown_next = countdown;
    unique case (mode)
      MODE_INITIAL: begin
        if (volt >= cfg.under_limit && volt <= cfg.over_limit) begin
          countdown_next = cd_dec;
          if (expired) mode_next = MODE_NORMAL;
        end else begin
          countdown_next = cfg.first_delay;
        end
      end
      MODE_NORMAL: begin
        priority if (volt > cfg.over_limit) begin
          countdown_next = cfg.recover_delay;
          mode_next      = MODE_OVER;
        end else if (volt < cfg.under_limit) begin
          countdown_next = cfg.recover_delay;
          mode_next      = MODE_UNDER;
        end
      end
      MODE_OVER: begin
        priority if (volt > cfg.over_recover_limit) begin
          countdown_next = cfg.recover_delay;
        end else if (volt < cfg.under_limit) begin
          countdown_next = cfg.recover_delay;
          mode_next      = MODE_UNDER;
        end else begin
          countdown_next = cd_dec;
          if (expired) mode_next = MODE_NORMAL;
        end
      end
      MODE_UNDER: begin
        priority if (volt > cfg.over_limit) begin
          countdown_next = cfg.recover_delay;
          mode_next      = MODE_OVER;
        end else if (volt < cfg.under_recover_limit) begin
          countdown_next = cfg.recover_delay;
        end else begin
          countdown_next = cd_dec;
          if (expired) mode_next = MODE_NORMAL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_INITIAL;
      countdown <= RST_FIRST_DELAY;
    end else if (step) begin
      mode      <= mode_next;
      countdown <= countdown_next;
    end
  end

endmodule

>>> hw/rtl/supply_voltage_window_monitor_top.sv
// ----------------------------------------------------------------------------
// supply_voltage_window_monitor_top
// Input register, classification state machine and result register.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register; once the output can advance, its
// result and out_valid are loaded into the result register.
// Throughput: 1 item per cycle unless out_stall holds a valid result; the state
// update feeds straight back into the state registers. Reset: synchronous; state
// initial, countdown 10, registers at defaults, both pipeline registers empty.
module supply_voltage_window_monitor_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [svwm_pkg::AddrW-1:0]  paddr,
  input  logic [svwm_pkg::DataW-1:0]  pwdata,
  output logic [svwm_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [svwm_pkg::VoltW-1:0]  voltage_decivolts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [svwm_pkg::StateW-1:0] supply_state
);
  import svwm_pkg::*;

  cfg_t              cfg;
  logic              in_q_valid;
  logic [VoltW-1:0]  in_q_volt;
  logic              advance;
  logic              step;
  logic [StateW-1:0] mode;
  logic [StateW-1:0] mode_next;
  logic [DelayW-1:0] countdown;

  svwm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !out_valid || !out_stall;
  assign step     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_volt <= voltage_decivolts;
    end
  end

  svwm_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .volt      (in_q_volt),
    .cfg       (cfg),
    .mode      (mode),
    .mode_next (mode_next),
    .countdown (countdown)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      supply_state <= mode_next;
    end
  end

`ifndef SYNTHESIS
  a_result_is_state: assert property (@(posedge clk) disable iff (rst)
    step |=> supply_state == mode)
    else $error("result differs from state");

  a_hold_without_item: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(mode) && $stable(countdown))
    else $error("state moved without an item");

  a_normal_entry: assert property (@(posedge clk) disable iff (rst)
    step && mode != MODE_NORMAL && mode_next == MODE_NORMAL |=> countdown == '0)
    else $error("countdown not cleared on entry to normal");

  a_normal_hold: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_NORMAL && mode_next == MODE_NORMAL |=> $stable(countdown))
    else $error("countdown changed in normal state");
`endif

endmodule
